@@ hdl/assert_macros.svh @@
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RMEZ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define RMEZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define RMEZ_ASSERT(lbl, clk, rst_n, prop)
`define RMEZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/rmez_pkg.sv @@
package rmez_pkg;

	localparam int IN_W          = 16;
	localparam int GUARD_BITS    = 16;
	localparam int CORDIC_STEPS  = 16;
	localparam int TABLE_LEN     = 24;
	localparam int CORDIC_NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	// sum of squares and its root with guard bits appended below
	localparam int SQ_W      = 2 * IN_W;
	localparam int ISQ_STEPS = (SQ_W + 2 * GUARD_BITS) / 2;

	// cordic operand widths: input fits a guarded 17-bit value, gain needs 3 more
	localparam int CIN_W = IN_W + GUARD_BITS + 1;
	localparam int CW    = CIN_W + 3;

	localparam int ANG_FRAC   = 20;
	localparam int OUT_FRAC   = 7;
	localparam int Z_W        = 30;
	localparam int ROUND_SH   = ANG_FRAC - OUT_FRAC;
	localparam int ROUND_BIAS = 1 << (ROUND_SH - 1);
	localparam int RND_W      = Z_W + 1 - ROUND_SH;

	localparam int YAW_W   = 16;
	localparam int PITCH_W = 15;
	localparam int ROLL_W  = 16;
	localparam int IN_TDATA_W  = ((5 * IN_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((YAW_W + PITCH_W + ROLL_W + 7) / 8) * 8;

	// pitch operands wait for the root: input reg, sum reg, root pipeline
	localparam int ALIGN_DLY = ISQ_STEPS + 1;
	localparam int PIPE_LAT  = 2 + ISQ_STEPS + CORDIC_NSTEPS + 1 + 1;

	typedef logic signed [Z_W-1:0]   z_t;
	typedef logic signed [CIN_W-1:0] cin_t;
	typedef logic signed [RND_W-1:0] rnd_t;

	localparam z_t   Z_90      = Z_W'(90 * (1 << ANG_FRAC));
	localparam rnd_t YAW_LIM   = RND_W'(23040);
	localparam rnd_t PITCH_LIM = RND_W'(11520);

	// atan(2^-i) in degrees, 20 fraction bits
	function automatic z_t atan_tab(input int i);
		z_t v;
		unique case (i)
			0:  v = Z_W'(47185920);
			1:  v = Z_W'(27855475);
			2:  v = Z_W'(14718068);
			3:  v = Z_W'(7471121);
			4:  v = Z_W'(3750058);
			5:  v = Z_W'(1876857);
			6:  v = Z_W'(938658);
			7:  v = Z_W'(469357);
			8:  v = Z_W'(234682);
			9:  v = Z_W'(117342);
			10: v = Z_W'(58671);
			11: v = Z_W'(29335);
			12: v = Z_W'(14668);
			13: v = Z_W'(7334);
			14: v = Z_W'(3667);
			15: v = Z_W'(1833);
			16: v = Z_W'(917);
			17: v = Z_W'(458);
			18: v = Z_W'(229);
			19: v = Z_W'(115);
			20: v = Z_W'(57);
			21: v = Z_W'(29);
			22: v = Z_W'(14);
			23: v = Z_W'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/rmez_isqrt.sv @@
// pipelined digit-by-digit square root of (sq_in << 2*GUARD_BITS), one root bit per stage
module rmez_isqrt (
	input  logic                            clk,
	input  logic                            en,
	input  logic [rmez_pkg::SQ_W-1:0]       sq_in,
	output logic [rmez_pkg::ISQ_STEPS-1:0]  root_out
);

	localparam int N     = rmez_pkg::ISQ_STEPS;
	localparam int REM_W = N + 2;
	localparam int TR_W  = REM_W + 2;

	logic [REM_W-1:0]          rem_s  [1:N];
	logic [N-1:0]              root_s [1:N];
	logic [rmez_pkg::SQ_W-1:0] n_s    [1:N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_step
			logic [REM_W-1:0]          rem_in;
			logic [N-1:0]              root_in;
			logic [rmez_pkg::SQ_W-1:0] n_in;
			logic [TR_W-1:0]           trial;
			logic [TR_W-1:0]           sub;
			logic                      fits;

			if (k == 0) begin : g_first
				assign rem_in  = '0;
				assign root_in = '0;
				assign n_in    = sq_in;
			end else begin : g_next
				assign rem_in  = rem_s[k];
				assign root_in = root_s[k];
				assign n_in    = n_s[k];
			end

			// bring down the next two bits; guard bits below sq shift in as zeros
			assign trial = {rem_in, n_in[rmez_pkg::SQ_W-1 -: 2]};
			assign sub   = {{(TR_W - N - 2){1'b0}}, root_in, 2'b01};
			assign fits  = (trial >= sub);

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1]  <= fits ? REM_W'(trial - sub) : REM_W'(trial);
					root_s[k+1] <= {root_in[N-2:0], fits};
					n_s[k+1]    <= {n_in[rmez_pkg::SQ_W-3:0], 2'b00};
				end
			end
		end
	endgenerate

	assign root_out = root_s[N];

endmodule

@@ hdl/rmez_cordic.sv @@
// pipelined cordic vectoring atan2(y_in, x_in): one fold stage, then one micro-rotation per stage
module rmez_cordic (
	input  logic                clk,
	input  logic                en,
	input  rmez_pkg::cin_t      x_in,
	input  rmez_pkg::cin_t      y_in,
	output rmez_pkg::z_t        z_out
);

	localparam int N  = rmez_pkg::CORDIC_NSTEPS;
	localparam int CW = rmez_pkg::CW;

	logic signed [CW-1:0] x_s    [0:N];
	logic signed [CW-1:0] y_s    [0:N];
	rmez_pkg::z_t         z_s    [0:N];
	logic                 zero_s [0:N];

	logic signed [CW-1:0] xw, yw, fx, fy;
	rmez_pkg::z_t         fz;

	assign xw = CW'(x_in);
	assign yw = CW'(y_in);

	// quarter turn into the right half plane; y of zero counts as upper
	always_comb begin
		if (xw < 0) begin
			if (yw >= 0) begin
				fx = yw;
				fy = -xw;
				fz = rmez_pkg::Z_90;
			end else begin
				fx = -yw;
				fy = xw;
				fz = -rmez_pkg::Z_90;
			end
		end else begin
			fx = xw;
			fy = yw;
			fz = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= fx;
			y_s[0]    <= fy;
			z_s[0]    <= fz;
			zero_s[0] <= (x_in == '0) && (y_in == '0);
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					if (!y_s[k][CW-1]) begin
						x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
						y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
						z_s[k+1] <= z_s[k] + rmez_pkg::atan_tab(k);
					end else begin
						x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
						y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
						z_s[k+1] <= z_s[k] - rmez_pkg::atan_tab(k);
					end
					zero_s[k+1] <= zero_s[k];
				end
			end
		end
	endgenerate

	assign z_out = zero_s[N] ? '0 : z_s[N];

endmodule

@@ hdl/rotation_matrix_to_euler_zyx.sv @@
// Z-Y-X Euler angles from a rotation matrix. One matrix (r11, r21, r31, r32, r33, signed Q2.14)
// is taken per cycle unless the output stalls, and yaw, pitch and roll come out in units of 1/128
// degree, saturated to +-180, +-90 and +-180 degrees. The path runs through an input register, the
// squaring and sum, a 32-stage square root pipeline for the pitch denominator, a 17-stage cordic
// (quarter-turn fold plus 16 micro-rotations) and the rounding output register; yaw and roll run
// their cordics early and wait in delay lines. The whole pipeline advances whenever the output
// register is empty or being taken, so backpressure on m_tready stalls every stage at once and no
// word is lost or repeated.
`include "assert_macros.svh"

module rotation_matrix_to_euler_zyx (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// elem_r11, elem_r21, elem_r31, elem_r32, elem_r33
	input  logic [rmez_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// yaw_deg, pitch_deg, roll_deg, zero pad
	output logic [rmez_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	localparam int IN_W = rmez_pkg::IN_W;

	logic                          pipe_en;
	logic [rmez_pkg::PIPE_LAT-1:0] vld_q;

	logic signed [IN_W-1:0]   e_r11, e_r21, e_r31, e_r32, e_r33;
	logic signed [2*IN_W-1:0] p32, p33;

	logic signed [IN_W-1:0]     r11_s1, r21_s1, r32_s1, r33_s1;
	logic signed [IN_W:0]       nr31_s1;
	logic [rmez_pkg::SQ_W-1:0]  sq32_s1, sq33_s1;
	logic [rmez_pkg::SQ_W-1:0]  sq_s2;

	logic signed [IN_W:0]       nr31_dly_q [0:rmez_pkg::ALIGN_DLY-1];
	rmez_pkg::z_t               yaw_dly_q  [0:rmez_pkg::ALIGN_DLY-1];
	rmez_pkg::z_t               roll_dly_q [0:rmez_pkg::ALIGN_DLY-1];

	logic [rmez_pkg::ISQ_STEPS-1:0] root;
	rmez_pkg::cin_t yaw_x, yaw_y, roll_x, roll_y, pitch_x, pitch_y;
	rmez_pkg::z_t   yaw_z, roll_z, pitch_z;
	rmez_pkg::rnd_t yaw_r, pitch_r, roll_r;

	logic [rmez_pkg::OUT_TDATA_W-1:0] res_q;

	function automatic rmez_pkg::rnd_t round_sat(input rmez_pkg::z_t z,
	                                            input rmez_pkg::rnd_t lim);
		logic signed [rmez_pkg::Z_W:0] zr;
		rmez_pkg::rnd_t                v;
		zr = {z[rmez_pkg::Z_W-1], z} + (rmez_pkg::Z_W + 1)'(rmez_pkg::ROUND_BIAS);
		v  = zr[rmez_pkg::Z_W:rmez_pkg::ROUND_SH];
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	assign pipe_en  = !m_tvalid || m_tready;
	assign s_tready = pipe_en;
	assign m_tvalid = vld_q[rmez_pkg::PIPE_LAT-1];
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[rmez_pkg::PIPE_LAT-2:0], s_tvalid};
		end
	end

	assign e_r11 = s_tdata[0*IN_W +: IN_W];
	assign e_r21 = s_tdata[1*IN_W +: IN_W];
	assign e_r31 = s_tdata[2*IN_W +: IN_W];
	assign e_r32 = s_tdata[3*IN_W +: IN_W];
	assign e_r33 = s_tdata[4*IN_W +: IN_W];
	assign p32   = e_r32 * e_r32;
	assign p33   = e_r33 * e_r33;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			r11_s1  <= e_r11;
			r21_s1  <= e_r21;
			r32_s1  <= e_r32;
			r33_s1  <= e_r33;
			nr31_s1 <= -((IN_W + 1)'(e_r31));
			sq32_s1 <= p32;
			sq33_s1 <= p33;
			sq_s2   <= sq32_s1 + sq33_s1;
		end
	end

	rmez_isqrt u_isqrt (
		.clk      (clk),
		.en       (pipe_en),
		.sq_in    (sq_s2),
		.root_out (root)
	);

	assign yaw_x  = rmez_pkg::cin_t'(r11_s1) <<< rmez_pkg::GUARD_BITS;
	assign yaw_y  = rmez_pkg::cin_t'(r21_s1) <<< rmez_pkg::GUARD_BITS;
	assign roll_x = rmez_pkg::cin_t'(r33_s1) <<< rmez_pkg::GUARD_BITS;
	assign roll_y = rmez_pkg::cin_t'(r32_s1) <<< rmez_pkg::GUARD_BITS;

	rmez_cordic u_yaw (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  (yaw_x),
		.y_in  (yaw_y),
		.z_out (yaw_z)
	);

	rmez_cordic u_roll (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  (roll_x),
		.y_in  (roll_y),
		.z_out (roll_z)
	);

	// -r31 waits for the root, yaw and roll angles wait for pitch
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			nr31_dly_q[0] <= nr31_s1;
			yaw_dly_q[0]  <= yaw_z;
			roll_dly_q[0] <= roll_z;
			for (int i = 1; i < rmez_pkg::ALIGN_DLY; i++) begin
				nr31_dly_q[i] <= nr31_dly_q[i-1];
				yaw_dly_q[i]  <= yaw_dly_q[i-1];
				roll_dly_q[i] <= roll_dly_q[i-1];
			end
		end
	end

	assign pitch_x = {1'b0, root};
	assign pitch_y = rmez_pkg::cin_t'(nr31_dly_q[rmez_pkg::ALIGN_DLY-1]) <<< rmez_pkg::GUARD_BITS;

	rmez_cordic u_pitch (
		.clk   (clk),
		.en    (pipe_en),
		.x_in  (pitch_x),
		.y_in  (pitch_y),
		.z_out (pitch_z)
	);

	assign yaw_r   = round_sat(yaw_dly_q[rmez_pkg::ALIGN_DLY-1], rmez_pkg::YAW_LIM);
	assign roll_r  = round_sat(roll_dly_q[rmez_pkg::ALIGN_DLY-1], rmez_pkg::YAW_LIM);
	assign pitch_r = round_sat(pitch_z, rmez_pkg::PITCH_LIM);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			res_q <= {{(rmez_pkg::OUT_TDATA_W - rmez_pkg::YAW_W - rmez_pkg::PITCH_W
			            - rmez_pkg::ROLL_W){1'b0}},
			          roll_r[rmez_pkg::ROLL_W-1:0],
			          pitch_r[rmez_pkg::PITCH_W-1:0],
			          yaw_r[rmez_pkg::YAW_W-1:0]};
		end
	end

	`RMEZ_ASSERT(a_accept_enters, clk, arst_n, (s_tvalid && s_tready) |=> vld_q[0])
	`RMEZ_ASSERT(a_stall_holds_chain, clk, arst_n, !pipe_en |=> $stable(vld_q))
	`RMEZ_ASSERT_IMP(a_yaw_range, clk, arst_n, m_tvalid,
		($signed(m_tdata[15:0]) <= rmez_pkg::YAW_LIM)
		&& ($signed(m_tdata[15:0]) >= -rmez_pkg::YAW_LIM))
	`RMEZ_ASSERT_IMP(a_pitch_range, clk, arst_n, m_tvalid,
		($signed(m_tdata[30:16]) <= rmez_pkg::PITCH_LIM)
		&& ($signed(m_tdata[30:16]) >= -rmez_pkg::PITCH_LIM))

endmodule

@@ verif/rotation_matrix_to_euler_zyx_tb.sv @@
module rotation_matrix_to_euler_zyx_tb;

	localparam int       N_RANDOM    = 750;
	localparam int       CYCLE_LIMIT = 200000;
	localparam int       STEPS       = 16;
	localparam int       GUARD       = 16;
	localparam longint   QUARTER     = 64'sd94371840;  // 90 degrees, 20 fraction bits
	localparam real      PI          = 3.14159265358979323846;

	// yaw sits in the lowest bits of the output word
	typedef struct packed {
		logic [15:0] roll;
		logic [14:0] pitch;
		logic [15:0] yaw;
	} angles_t;

	typedef struct packed {
		logic [79:0] mat;
		bit          known;
		angles_t     want;
	} stim_row_t;

	// atan(2^-i) in degrees, 20 fraction bits
	localparam longint ATAN_DEG [STEPS] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833
	};

	logic                              clk;
	logic                              arst_n;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [rmez_pkg::IN_TDATA_W-1:0]   s_tdata;
	logic                              m_tvalid;
	logic                              m_tready;
	logic [rmez_pkg::OUT_TDATA_W-1:0]  m_tdata;

	angles_t   angle_queue [$];
	stim_row_t directed_rows [$];
	int        errors;
	int        checked;
	int        rotations;
	int        tx_idle_pct;
	int        rx_stall_pct;
	int        cycle_count;
	angles_t   got;
	angles_t   want;

	rotation_matrix_to_euler_zyx u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root;
		longint unsigned one_bit;
		root = 0;
		one_bit = 64'd1 << 62;
		while (one_bit > n)
			one_bit = one_bit >> 2;
		while (one_bit != 0) begin
			if (n >= root + one_bit) begin
				n = n - (root + one_bit);
				root = (root >> 1) + one_bit;
			end else begin
				root = root >> 1;
			end
			one_bit = one_bit >> 2;
		end
		return root;
	endfunction

	// vectoring atan2 in degrees, 20 fraction bits
	function automatic longint atan2_deg(input longint y, input longint x);
		longint z;
		longint t;
		longint xs;
		longint ys;
		z = 0;
		if (x == 0 && y == 0)
			return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y;
				y = -t;
				z = QUARTER;
			end else begin
				x = -y;
				y = t;
				z = -QUARTER;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_DEG[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_DEG[i];
			end
		end
		return z;
	endfunction

	function automatic longint round_sat(input longint z, input longint lim);
		longint v;
		v = (z + 4096) >>> 13;
		if (v > lim)
			v = lim;
		if (v < -lim)
			v = -lim;
		return v;
	endfunction

	function automatic angles_t predict_angles(input logic [79:0] mat);
		longint  r11;
		longint  r21;
		longint  r31;
		longint  r32;
		longint  r33;
		longint  mag;
		longint  v;
		angles_t a;
		r11 = $signed(mat[15:0]);
		r21 = $signed(mat[31:16]);
		r31 = $signed(mat[47:32]);
		r32 = $signed(mat[63:48]);
		r33 = $signed(mat[79:64]);
		mag = longint'(int_sqrt(longint'(r32 * r32 + r33 * r33) << (2 * GUARD)));
		v = round_sat(atan2_deg(r21 <<< GUARD, r11 <<< GUARD), 23040);
		a.yaw = v[15:0];
		v = round_sat(atan2_deg(-(r31 <<< GUARD), mag), 11520);
		a.pitch = v[14:0];
		v = round_sat(atan2_deg(r32 <<< GUARD, r33 <<< GUARD), 23040);
		a.roll = v[15:0];
		return a;
	endfunction

	function automatic logic [79:0] pack_mat(input int r11, input int r21, input int r31,
			input int r32, input int r33);
		return {r33[15:0], r32[15:0], r31[15:0], r21[15:0], r11[15:0]};
	endfunction

	task automatic add_row(input int r11, input int r21, input int r31, input int r32,
			input int r33, input bit known);
		stim_row_t row;
		row.mat = pack_mat(r11, r21, r31, r32, r33);
		row.known = known;
		// only the all-zero matrix is typed in: every atan2 of a zero pair is 0
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic send_matrix(input logic [79:0] mat, input bit known, input angles_t typed);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= mat;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		angle_queue.push_back(known ? typed : predict_angles(mat));
	endtask

	task automatic check_field(input string name, input longint exp_v, input longint act_v);
		if (exp_v != act_v) begin
			errors++;
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name,
				exp_v, act_v);
		end
	endtask

	function automatic int rand_elem();
		int k;
		k = $urandom_range(5);
		unique case (k)
			0: return 0;
			1: return -32768;
			2: return 32767;
			3: return $urandom_range(3);
			4: return -int'($urandom_range(3));
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout with %0d word(s) outstanding", angle_queue.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[46:0];
			if (angle_queue.size() == 0) begin
				errors++;
				$display("%0t unexpected word: expected none, actual %h", $time, m_tdata);
			end else begin
				want = angle_queue.pop_front();
				check_field("yaw", $signed(want.yaw), $signed(got.yaw));
				check_field("pitch", $signed(want.pitch), $signed(got.pitch));
				check_field("roll", $signed(want.roll), $signed(got.roll));
				check_field("pad", 0, m_tdata[47]);
				checked++;
			end
		end
	end

	initial begin
		real ang_z;
		real ang_y;
		real ang_x;
		int  e [5];
		int  k;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		checked = 0;
		rotations = 0;
		cycle_count = 0;
		tx_idle_pct = 36;
		rx_stall_pct = 59;

		// zero vector, identity, extremes, negative x axis, gimbal lock, bit patterns
		add_row(0, 0, 0, 0, 0, 1'b1);
		add_row(16384, 0, 0, 0, 16384, 1'b0);
		add_row(-32768, -32768, -32768, -32768, -32768, 1'b0);
		add_row(32767, 32767, 32767, 32767, 32767, 1'b0);
		add_row(-32768, 0, 0, 0, -32768, 1'b0);
		add_row(-16384, 0, 0, 0, -1, 1'b0);
		add_row(-32768, -1, 0, -1, -32768, 1'b0);
		add_row(0, 32767, -32768, 0, 0, 1'b0);
		add_row(0, -32768, 32767, 0, 0, 1'b0);
		add_row(0, 0, -16384, 0, 0, 1'b0);
		add_row(0, 0, 16384, 0, 0, 1'b0);
		add_row(32767, 0, 0, -32768, -32768, 1'b0);
		add_row(1, -1, -1, 1, -1, 1'b0);
		add_row(-1, 1, 1, -1, 1, 1'b0);
		add_row(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0);
		add_row(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b0);
		add_row(0, 16384, 0, 16384, 0, 1'b0);
		add_row(11585, 11585, -11585, 11585, 11585, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_matrix(directed_rows[i].mat, directed_rows[i].known, directed_rows[i].want);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 3) begin
				tx_idle_pct = 59;
				rx_stall_pct = 36;
			end else if (n == 2 * N_RANDOM / 3) begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			k = $urandom_range(99);
			if (k < 50) begin
				// proper rotation, with the occasional gimbal lock
				ang_z = (real'($urandom_range(3600)) / 10.0 - 180.0) * PI / 180.0;
				ang_x = (real'($urandom_range(3600)) / 10.0 - 180.0) * PI / 180.0;
				if ($urandom_range(9) == 0)
					ang_y = ($urandom_range(1) ? 90.0 : -90.0) * PI / 180.0;
				else
					ang_y = (real'($urandom_range(1800)) / 10.0 - 90.0) * PI / 180.0;
				e[0] = $rtoi(16384.0 * $cos(ang_z) * $cos(ang_y));
				e[1] = $rtoi(16384.0 * $sin(ang_z) * $cos(ang_y));
				e[2] = $rtoi(-16384.0 * $sin(ang_y));
				e[3] = $rtoi(16384.0 * $cos(ang_y) * $sin(ang_x));
				e[4] = $rtoi(16384.0 * $cos(ang_y) * $cos(ang_x));
				rotations++;
			end else if (k < 80) begin
				foreach (e[j])
					e[j] = int'($urandom_range(65535)) - 32768;
			end else begin
				foreach (e[j])
					e[j] = rand_elem();
			end
			send_matrix(pack_mat(e[0], e[1], e[2], e[3], e[4]), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (angle_queue.size() != 0)
			@(posedge clk);
		repeat (rmez_pkg::PIPE_LAT + 20) @(posedge clk);

		$display("sent %0d directed and %0d random matrices (%0d proper rotations)",
			directed_rows.size(), N_RANDOM, rotations);
		$display("compared %0d angle words under three idle/stall mixes, %0d mismatches",
			checked, errors);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rmez_pkg.sv
hdl/rmez_isqrt.sv
hdl/rmez_cordic.sv
hdl/rotation_matrix_to_euler_zyx.sv
verif/rotation_matrix_to_euler_zyx_tb.sv
